// File: src/wqcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quantile cut points - shared package
// Defaults, fixed-point constants and the sequencer state type.
// ----------------------------------------------------------------------------
package wqcp_pkg;

	localparam int MAX_SAMPLES_DEF    = 1024;
	localparam int MAX_CANDIDATES_DEF = 128;

	localparam int VAL_W  = 32;
	localparam int HESS_W = 32;
	localparam int STEP_W = 17;
	localparam int RANK_W = 17;
	localparam int FRAC_W = 16;

	localparam logic [STEP_W-1:0] RANK_STEP_RST = 17'd655;
	localparam logic [VAL_W-1:0]  SIGN_BIAS     = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_W_RD,
		ST_W_CMP,
		ST_DIV
	} state_t;

endpackage

// File: src/wqcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quantile cut points - simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wqcp_ram #(
	parameter int Depth = 1024,
	parameter int Width = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/wqcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quantile cut points - rank divider
// Restoring division of (num << 16) by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wqcp_div #(
	parameter int Bw = 43
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [Bw-1:0]              num,
	input  logic [Bw-1:0]              den,
	output logic                       done,
	output logic [wqcp_pkg::RANK_W-1:0] quo
);

	localparam int RW = Bw + wqcp_pkg::FRAC_W;
	localparam int CW = $clog2(wqcp_pkg::RANK_W + 1);

	logic [RW-1:0]               r_q;
	logic [RW-1:0]               d_q;
	logic [wqcp_pkg::RANK_W-1:0] q_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        ge;

	assign ge = r_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			d_q    <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				r_q    <= {num, {wqcp_pkg::FRAC_W{1'b0}}};
				d_q    <= {den, {wqcp_pkg::FRAC_W{1'b0}}};
				q_q    <= '0;
				cnt_q  <= CW'(wqcp_pkg::RANK_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					r_q <= r_q - d_q;
				end
				q_q   <= {q_q[wqcp_pkg::RANK_W-2:0], ge};
				d_q   <= d_q >> 1;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// File: src/weighted_quantile_cut_points.sv
`timescale 1ns / 1ps
// Load word: input stalls while insertion reads stored samples from the top, shifts each larger
// one up one place and writes the new sample into the gap; a first sample is written at once.
// Read word: registered RAM data and status feed the output word; one per cycle unless stalled.
// Last sample: the walk reads each sample in turn, running the divider for each new distinct value.
// The sample RAM has one read and one write port, so insertion reads each entry before shifting it.
// Reset clears counts and flags and sets rank_step to 655; RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
// Weighted quantile cut points - top level
// Keeps samples sorted in RAM as they arrive, then walks them once to pick
// hessian-weighted quantile cut points into the candidate RAM.
// ----------------------------------------------------------------------------
module weighted_quantile_cut_points #(
	parameter int MaxSamples    = wqcp_pkg::MAX_SAMPLES_DEF,
	parameter int MaxCandidates = wqcp_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [wqcp_pkg::STEP_W-1:0]   cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic signed [31:0]            feature_value,
	input  logic [31:0]                   hessian,
	input  logic                          last_sample,
	input  logic [6:0]                    read_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            candidate_value,
	output logic                          index_valid,
	output logic [7:0]                    candidate_count,
	output logic                          overflow_flag,
	output logic                          zero_total_flag
);

	localparam int SAW = $clog2(MaxSamples);
	localparam int SCW = $clog2(MaxSamples + 1);
	localparam int CAW = $clog2(MaxCandidates);
	localparam int CCW = $clog2(MaxCandidates + 1);
	localparam int TW  = wqcp_pkg::HESS_W + SCW;
	localparam int VW  = wqcp_pkg::VAL_W;
	localparam int HW  = wqcp_pkg::HESS_W;
	localparam int RW  = wqcp_pkg::RANK_W;

	wqcp_pkg::state_t state_q, state_nx;

	// configuration
	logic [wqcp_pkg::STEP_W-1:0] rank_step_q;

	// load / insertion registers
	logic [SCW-1:0] count_q;
	logic [SAW-1:0] j_q;
	logic [VW-1:0]  k_q;
	logic [HW-1:0]  h_q;
	logic           last_q;
	logic [TW-1:0]  total_q;

	// walk registers
	logic [SCW-1:0] i_q;
	logic [SCW-1:0] i_inc;
	logic [TW-1:0]  below_q;
	logic [VW-1:0]  prev_q;
	logic [VW-1:0]  cur_key_q;
	logic [HW-1:0]  cur_h_q;
	logic [RW-1:0]  last_rank_q;
	logic [CCW-1:0] cand_cnt_q;
	logic           ovf_q;
	logic           zero_q;

	// read path
	logic           s1_valid_q;
	logic           s1_ok_q;
	logic [7:0]     s1_cnt_q;
	logic           s1_ovf_q;
	logic           s1_zero_q;
	logic           out_load;

	// RAM ports
	logic             sm_we, sm_re;
	logic [SAW-1:0]   sm_waddr, sm_raddr;
	logic [VW+HW-1:0] sm_wdata, sm_rdata;
	logic [VW-1:0]    rd_key;
	logic [HW-1:0]    rd_h;
	logic             cm_we;
	logic [CAW-1:0]   cm_waddr, cm_raddr;
	logic [VW-1:0]    cm_wdata, cm_rdata;

	// divider
	logic          div_start, div_done;
	logic [RW-1:0] div_q;

	logic acc_load, acc_read;
	logic walk_last, cand_room, rank_pass, ins_gt, walk_gt;

	assign in_stall = (state_q != wqcp_pkg::ST_IDLE) || (s1_valid_q && out_valid && out_stall);
	assign acc_load = in_valid && !in_stall && !req_type;
	assign acc_read = in_valid && !in_stall && req_type;
	assign out_load = s1_valid_q && (!out_valid || !out_stall);

	assign {rd_key, rd_h} = sm_rdata;
	assign i_inc     = i_q + SCW'(1);
	assign walk_last = (i_inc == count_q);
	assign cand_room = 32'(cand_cnt_q) < MaxCandidates;
	assign ins_gt    = rd_key > k_q;
	assign walk_gt   = rd_key > prev_q;
	assign rank_pass = (div_q >= last_rank_q) &&
	                   ((div_q - last_rank_q) >= rank_step_q);

	wqcp_ram #(.Depth(MaxSamples), .Width(VW + HW)) u_smem (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.re    (sm_re),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	wqcp_ram #(.Depth(MaxCandidates), .Width(VW)) u_cmem (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.re    (acc_read),
		.raddr (cm_raddr),
		.rdata (cm_rdata)
	);

	wqcp_div #(.Bw(TW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (below_q),
		.den    (total_q),
		.done   (div_done),
		.quo    (div_q)
	);

	assign cm_raddr = CAW'(read_index);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			wqcp_pkg::ST_IDLE: begin
				if (acc_load) begin
					if (count_q == SCW'(MaxSamples)) begin
						state_nx = last_sample ? wqcp_pkg::ST_W_RD : wqcp_pkg::ST_IDLE;
					end else if (count_q == '0) begin
						state_nx = wqcp_pkg::ST_INS_WR;
					end else begin
						state_nx = wqcp_pkg::ST_INS_RD;
					end
				end
			end
			wqcp_pkg::ST_INS_RD: state_nx = wqcp_pkg::ST_INS_CMP;
			wqcp_pkg::ST_INS_CMP: begin
				if (ins_gt && j_q != SAW'(1)) begin
					state_nx = wqcp_pkg::ST_INS_RD;
				end else begin
					state_nx = wqcp_pkg::ST_INS_WR;
				end
			end
			wqcp_pkg::ST_INS_WR: begin
				state_nx = last_q ? wqcp_pkg::ST_W_RD : wqcp_pkg::ST_IDLE;
			end
			wqcp_pkg::ST_W_RD: state_nx = wqcp_pkg::ST_W_CMP;
			wqcp_pkg::ST_W_CMP: begin
				if (i_q == '0) begin
					state_nx = (total_q == '0 || walk_last) ? wqcp_pkg::ST_IDLE
					                                      : wqcp_pkg::ST_W_RD;
				end else if (walk_gt) begin
					state_nx = wqcp_pkg::ST_DIV;
				end else begin
					state_nx = walk_last ? wqcp_pkg::ST_IDLE : wqcp_pkg::ST_W_RD;
				end
			end
			wqcp_pkg::ST_DIV: begin
				if (div_done) begin
					state_nx = walk_last ? wqcp_pkg::ST_IDLE : wqcp_pkg::ST_W_RD;
				end
			end
			default: state_nx = wqcp_pkg::ST_IDLE;
		endcase
	end

	// RAM and divider controls
	always_comb begin
		sm_we     = 1'b0;
		sm_waddr  = j_q;
		sm_wdata  = {k_q, h_q};
		sm_re     = 1'b0;
		sm_raddr  = i_q[SAW-1:0];
		cm_we     = 1'b0;
		cm_waddr  = cand_cnt_q[CAW-1:0];
		cm_wdata  = cur_key_q ^ wqcp_pkg::SIGN_BIAS;
		div_start = 1'b0;
		case (state_q)
			wqcp_pkg::ST_INS_RD: begin
				sm_re    = 1'b1;
				sm_raddr = j_q - SAW'(1);
			end
			wqcp_pkg::ST_INS_CMP: begin
				// shift the larger entry up one place
				sm_we    = ins_gt;
				sm_wdata = sm_rdata;
			end
			wqcp_pkg::ST_INS_WR: sm_we = 1'b1;
			wqcp_pkg::ST_W_RD:   sm_re = 1'b1;
			wqcp_pkg::ST_W_CMP: begin
				if (i_q == '0) begin
					cm_we    = 1'b1;
					cm_waddr = '0;
					cm_wdata = rd_key ^ wqcp_pkg::SIGN_BIAS;
				end else begin
					div_start = walk_gt;
				end
			end
			wqcp_pkg::ST_DIV: cm_we = div_done && rank_pass && cand_room;
			default: ;
		endcase
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wqcp_pkg::ST_IDLE;
			rank_step_q <= wqcp_pkg::RANK_STEP_RST;
			count_q     <= '0;
			j_q         <= '0;
			k_q         <= '0;
			h_q         <= '0;
			last_q      <= 1'b0;
			total_q     <= '0;
			i_q         <= '0;
			below_q     <= '0;
			prev_q      <= '0;
			cur_key_q   <= '0;
			cur_h_q     <= '0;
			last_rank_q <= '0;
			cand_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			zero_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				rank_step_q <= cfg_wdata;
			end
			case (state_q)
				wqcp_pkg::ST_IDLE: begin
					if (acc_load) begin
						i_q    <= '0;
						last_q <= last_sample;
						if (count_q == '0) begin
							// a fresh load drops the previous results
							cand_cnt_q <= '0;
							ovf_q      <= 1'b0;
							zero_q     <= 1'b0;
						end
						if (count_q == SCW'(MaxSamples)) begin
							ovf_q <= 1'b1;
						end else begin
							k_q     <= feature_value ^ wqcp_pkg::SIGN_BIAS;
							h_q     <= hessian;
							j_q     <= count_q[SAW-1:0];
							count_q <= count_q + SCW'(1);
							total_q <= (count_q == '0) ? TW'(hessian)
							                           : total_q + TW'(hessian);
						end
					end
				end
				wqcp_pkg::ST_INS_CMP: begin
					if (ins_gt) begin
						j_q <= j_q - SAW'(1);
					end
				end
				wqcp_pkg::ST_W_CMP: begin
					if (i_q == '0) begin
						// lowest value always opens the list
						cand_cnt_q  <= CCW'(1);
						prev_q      <= rd_key;
						below_q     <= TW'(rd_h);
						last_rank_q <= '0;
						i_q         <= i_inc;
						if (total_q == '0) begin
							zero_q <= 1'b1;
						end
						if (total_q == '0 || walk_last) begin
							count_q <= '0;
						end
					end else if (walk_gt) begin
						cur_key_q <= rd_key;
						cur_h_q   <= rd_h;
					end else begin
						below_q <= below_q + TW'(rd_h);
						prev_q  <= rd_key;
						i_q     <= i_inc;
						if (walk_last) begin
							count_q <= '0;
						end
					end
				end
				wqcp_pkg::ST_DIV: begin
					if (div_done) begin
						if (rank_pass) begin
							last_rank_q <= div_q;
							if (cand_room) begin
								cand_cnt_q <= cand_cnt_q + CCW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						below_q <= below_q + TW'(cur_h_q);
						prev_q  <= cur_key_q;
						i_q     <= i_inc;
						if (walk_last) begin
							count_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Read path: capture status with the RAM read, then hold in the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q      <= 1'b0;
			s1_ok_q         <= 1'b0;
			s1_cnt_q        <= '0;
			s1_ovf_q        <= 1'b0;
			s1_zero_q       <= 1'b0;
			out_valid       <= 1'b0;
			candidate_value <= '0;
			index_valid     <= 1'b0;
			candidate_count <= '0;
			overflow_flag   <= 1'b0;
			zero_total_flag <= 1'b0;
		end else begin
			if (acc_read) begin
				s1_valid_q <= 1'b1;
				s1_ok_q    <= (32'(read_index) < 32'(cand_cnt_q)) &&
				              (32'(read_index) < MaxCandidates);
				s1_cnt_q   <= 8'(cand_cnt_q);
				s1_ovf_q   <= ovf_q;
				s1_zero_q  <= zero_q;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid       <= 1'b1;
				candidate_value <= s1_ok_q ? cm_rdata : '0;
				index_valid     <= s1_ok_q;
				candidate_count <= s1_cnt_q;
				overflow_flag   <= s1_ovf_q;
				zero_total_flag <= s1_zero_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// File: bench/wqcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quantile cut points - checker
// Watches both channels, keeps its own copy of the sample and candidate
// state, predicts each read word and compares it with the returned word.
// ----------------------------------------------------------------------------
module wqcp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] feature_value,
	input  logic [31:0]        hessian,
	input  logic               last_sample,
	input  logic [6:0]         read_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] candidate_value,
	input  logic               index_valid,
	input  logic [7:0]         candidate_count,
	input  logic               overflow_flag,
	input  logic               zero_total_flag,
	output int                 fail_count,
	output int                 pending_reads,
	output int                 reads_checked,
	output int                 loads_seen
);
	localparam int NS = 1024;
	localparam int NC = 128;

	typedef struct packed {
		logic signed [31:0] value;
		logic               valid;
		logic [7:0]         count;
		logic               ovf;
		logic               zero;
	} read_word_t;

	logic [31:0] keys   [NS];
	logic [31:0] hess   [NS];
	logic [31:0] cands  [NC];
	int          n_samp;
	int          n_cand;
	logic        f_ovf, f_zero;
	logic [16:0] step;
	read_word_t  expected_reads[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	task automatic push_candidate(input logic [31:0] key);
		if (n_cand < NC) begin
			cands[n_cand] = key ^ 32'h8000_0000;
			n_cand++;
		end else
			f_ovf = 1'b1;
	endtask

	// Sort by biased key, then walk the distinct values picking cut points.
	task automatic compute_cut_points();
		logic [31:0] sk [NS];
		logic [31:0] sh [NS];
		logic [31:0] k, h;
		logic [63:0] total, below, last_rank, rank;
		int j;
		if (n_samp == 0) return;
		for (int i = 0; i < n_samp; i++) begin
			k = keys[i] ^ 32'h8000_0000;
			h = hess[i];
			j = i;
			while (j > 0 && sk[j-1] > k) begin
				sk[j] = sk[j-1];
				sh[j] = sh[j-1];
				j--;
			end
			sk[j] = k;
			sh[j] = h;
		end
		total = 0;
		for (int i = 0; i < n_samp; i++) total += sh[i];
		n_cand = 0;
		push_candidate(sk[0]);
		if (total == 0) begin
			f_zero = 1'b1;
			return;
		end
		below = 0;
		last_rank = 0;
		for (int i = 1; i < n_samp; i++) begin
			below += sh[i-1];
			if (sk[i] > sk[i-1]) begin
				rank = (below << 16) / total;
				if (rank >= last_rank && rank - last_rank >= {47'd0, step}) begin
					push_candidate(sk[i]);
					last_rank = rank;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		read_word_t w;
		if (!arst_n) begin
			n_samp = 0; n_cand = 0; f_ovf = 0; f_zero = 0; step = 17'd655;
			fail_count = 0; reads_checked = 0; loads_seen = 0;
			expected_reads.delete();
		end else begin
			if (cfg_we) step = cfg_wdata;
			if (in_valid && !in_stall) begin
				if (req_type == 1'b0) begin
					loads_seen++;
					if (n_samp == 0) begin
						n_cand = 0; f_ovf = 0; f_zero = 0;
					end
					if (n_samp < NS) begin
						keys[n_samp] = feature_value;
						hess[n_samp] = hessian;
						n_samp++;
					end else
						f_ovf = 1'b1;
					if (last_sample) begin
						compute_cut_points();
						n_samp = 0;
					end
				end else begin
					w.valid = read_index < n_cand;
					w.value = w.valid ? cands[read_index] : 32'd0;
					w.count = n_cand[7:0];
					w.ovf   = f_ovf;
					w.zero  = f_zero;
					expected_reads.insert(expected_reads.size(), w);
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_reads.size() == 0)
					report("unexpected word", '0, '0);
				else begin
					w = expected_reads.pop_front();
					reads_checked++;
					if (candidate_value !== w.value)
						report("candidate_value", candidate_value, w.value);
					if (index_valid !== w.valid)
						report("index_valid", 32'(index_valid), 32'(w.valid));
					if (candidate_count !== w.count)
						report("candidate_count", 32'(candidate_count), 32'(w.count));
					if (overflow_flag !== w.ovf)
						report("overflow_flag", 32'(overflow_flag), 32'(w.ovf));
					if (zero_total_flag !== w.zero)
						report("zero_total_flag", 32'(zero_total_flag), 32'(w.zero));
				end
			end
		end
		pending_reads = expected_reads.size();
	end
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quantile cut points - testbench top
// Drives loads and candidate reads with bursty traffic and a stalling
// receiver, changes rank_step between loads and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [16:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = 1'b0;
	logic signed [31:0] feature_value = '0;
	logic [31:0]        hessian = '0;
	logic               last_sample = 1'b0;
	logic [6:0]         read_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] candidate_value;
	logic               index_valid;
	logic [7:0]         candidate_count;
	logic               overflow_flag;
	logic               zero_total_flag;
	int                 fail_count, pending_reads, reads_checked, loads_seen;
	bit                 hold_off = 1'b0;	// long receiver stall, set by the stimulus
	int                 items_sent = 0;

	always #5 clk = ~clk;

	weighted_quantile_cut_points u_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_stall, .req_type, .feature_value, .hessian,
		.last_sample, .read_index,
		.out_valid, .out_stall, .candidate_value, .index_valid,
		.candidate_count, .overflow_flag, .zero_total_flag
	);

	wqcp_checker u_chk (.*);

	// Receiver: stall on its own pattern, or hold solid while hold_off is up.
	initial begin
		int mode;
		forever begin
			@(posedge clk);
			mode = (items_sent / 300) % 3;
			if (hold_off) out_stall <= 1'b1;
			else if (mode == 0) out_stall <= 1'b0;
			else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
			else out_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	// Offer one word and hold it until accepted; gaps come from the burst logic.
	task automatic send_word(input logic rt, input logic [31:0] v, input logic [31:0] h,
			input logic last, input logic [6:0] idx);
		req_type <= rt;
		feature_value <= v;
		hessian <= h;
		last_sample <= last;
		read_index <= idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	int burst_left = 0;

	// Drop valid for a random gap when the current burst runs out.
	task automatic maybe_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 20);
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load(input logic [31:0] v, input logic [31:0] h, input logic last);
		maybe_gap();
		send_word(1'b0, v, h, last, 7'($urandom));
	endtask

	task automatic read_cand(input logic [6:0] idx);
		maybe_gap();
		send_word(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)), idx);
	endtask

	// Let the block drain, then a margin for a walk in progress, then write rank_step.
	task automatic set_step(input logic [16:0] s);
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		@(posedge clk);
		while (pending_reads != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60000) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Read back a spread of indices including past the count.
	task automatic read_set(input int n);
		for (int i = 0; i < n; i++)
			read_cand((i < 8) ? 7'(i) : 7'($urandom_range(0, 127)));
	endtask

	function automatic logic [31:0] rand_value(input int pool);
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return 32'($urandom_range(0, pool)) - 32'(pool / 2);
		endcase
	endfunction

	function automatic logic [31:0] rand_hess();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0003_0000);
		endcase
	endfunction

	initial begin
		int n, pool;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads before any load, extremes, duplicates, zero total.
		read_cand(7'd0);
		read_cand(7'd127);
		load(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		load(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		read_cand(7'd0);	// mid-load read sees count zero
		load(32'h0000_0000, 32'h0001_0000, 1'b0);
		load(32'h0000_0000, 32'h0001_0000, 1'b0);
		load(32'hFFFF_0000, 32'h0, 1'b1);
		read_set(6);
		load(32'h1234_5678, 32'h0, 1'b0);
		load(32'h0000_0001, 32'h0, 1'b1);	// zero total
		read_set(3);
		load(32'h5555_AAAA, 32'h1, 1'b1);	// single sample
		read_set(2);

		// Rank step zero: every distinct value kept, more than the store holds.
		set_step(17'd0);
		for (int i = 0; i < 150; i++)
			load(32'(i * 7 - 600), rand_hess(), i == 149);
		read_set(10);
		read_cand(7'd127);

		// Sample overflow with a dropped last sample, step set to 65536.
		set_step(17'd65536);
		for (int i = 0; i < 1030; i++)
			load($urandom, $urandom_range(1, 100), i == 1029);
		read_set(4);

		// Pressure: receiver holds off while the sender keeps offering reads.
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			read_set(40);
		join

		// Random loads with mixed steps, mostly small sets.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph % 4)
				0: set_step(17'd1);
				1: set_step(17'($urandom_range(1, 8000)));
				2: set_step(17'd655);
				default: set_step(17'($urandom_range(0, 65536)));
			endcase
			for (int s = 0; s < 6; s++) begin
				n = $urandom_range(1, 24);
				pool = (s % 2) ? 20 : 100000;
				for (int i = 0; i < n; i++) begin
					load(rand_value(pool), rand_hess(), i == n - 1);
					if ($urandom_range(0, 15) == 0) read_cand(7'($urandom));
				end
				read_set($urandom_range(3, 14));
			end
		end

		in_valid <= 1'b0;
		begin
			int guard;
			guard = 0;
			while (pending_reads != 0 && guard < 200000) begin
				@(posedge clk);
				guard++;
			end
		end
		repeat (50) @(posedge clk);
		$display("covered %0d words (%0d loads), %0d read words checked",
			items_sent, loads_seen, reads_checked);
		$display("rank_step swept from 0 to 65536 with sample and candidate overflow");
		if (fail_count == 0 && pending_reads == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Limit: generous bound well past the slowest correct run.
	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end
endmodule
